[rtl/l2mac_pkg.sv]
// Shared types and constants for the layer-2 MAC learning table.
// Used by l2mac_ram and l2_mac_learning_table; depends on nothing else.
package l2mac_pkg;

	localparam int VLAN_W = 12;
	localparam int MAC_W = 48;
	localparam int PORT_W = 3;
	localparam int KEY_W = VLAN_W + MAC_W;
	localparam int WORD_W = KEY_W + PORT_W;
	// Wide enough to hold the largest allowed port count for the range check.
	localparam int PORT_CMP_W = 9;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic              hit;
		logic              learned;
		logic              moved;
		logic              refreshed;
		logic              full_res;
		logic [PORT_W-1:0] found_port;
	} result_t;

endpackage

[rtl/l2mac_ram.sv]
// Table storage: one entry word {vlan, mac, port} per address.
// One write port and one registered read port; uses l2mac_pkg.
module l2mac_ram
	import l2mac_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/l2_mac_learning_table.sv]
// Layer-2 MAC learning table: top level with the search sequencer and result register.
// A miss reads every filled entry, a hit stops at the first match, and an empty table skips the scan;
// a result held by out_stall delays the next one. No request is taken while a search is in progress.
// The compare walks the memory one entry a cycle.
// Entries are only ever added in order, so the valid entries are always addresses below the fill count.
// Reset clears the fill count and all control state at once; the table memory itself needs no clearing pass.
module l2_mac_learning_table
	import l2mac_pkg::*;
#(
	parameter int TABLE_ENTRIES = 64,
	parameter int NUM_PORTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [VLAN_W-1:0] vlan,
	input  logic [MAC_W-1:0]  mac,
	input  logic [PORT_W-1:0] port,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              learned,
	output logic              moved,
	output logic              refreshed,
	output logic              full_res,
	output logic [PORT_W-1:0] found_port
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     rd_idx_q;
	logic              cmp_vld_s1;
	logic [AW-1:0]     cmp_idx_s1;
	logic              found_q;
	logic [AW-1:0]     hit_idx_q;
	logic [PORT_W-1:0] hit_port_q;
	logic              mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [PORT_W-1:0] port_q;
	logic              out_valid_q;
	result_t           res_q;

	logic              in_accept;
	logic              rd_en;
	logic [WORD_W-1:0] rd_word;
	logic              key_match;
	logic              scan_miss;
	logic              finish_load;
	logic              port_ok;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	result_t           res_d;

	assign in_stall = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign rd_en = (state_q == ST_SCAN) && (rd_idx_q < cnt_q);
	assign key_match = cmp_vld_s1 && (rd_word[WORD_W-1:PORT_W] == key_q);
	assign scan_miss = cmp_vld_s1 && !key_match && !rd_en;
	assign finish_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign port_ok = (PORT_CMP_W'(port_q) < PORT_CMP_W'(NUM_PORTS));

	l2mac_ram #(
		.DEPTH(TABLE_ENTRIES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data({key_q, port_q}),
		.rd_en(rd_en),
		.rd_addr(rd_idx_q[AW-1:0]),
		.rd_data(rd_word)
	);

	// Outcome of the finished search, and the write-back for a move or an insert.
	always_comb begin
		res_d = '0;
		wr_en = 1'b0;
		wr_addr = hit_idx_q;
		if (mode_q) begin
			res_d.hit = found_q;
			res_d.found_port = found_q ? hit_port_q : '0;
		end else if (port_ok) begin
			if (found_q) begin
				res_d.hit = 1'b1;
				if (hit_port_q != port_q) begin
					res_d.moved = 1'b1;
					wr_en = finish_load;
				end else begin
					res_d.refreshed = 1'b1;
				end
			end else if (cnt_q < CW'(TABLE_ENTRIES)) begin
				res_d.learned = 1'b1;
				wr_en = finish_load;
				wr_addr = cnt_q[AW-1:0];
			end else begin
				res_d.full_res = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rd_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						rd_idx_q <= '0;
						cmp_vld_s1 <= 1'b0;
						found_q <= 1'b0;
						state_q <= (cnt_q == '0) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (key_match) begin
						found_q <= 1'b1;
						state_q <= ST_FINISH;
					end else if (scan_miss) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					cmp_vld_s1 <= 1'b0;
					if (finish_load) begin
						out_valid_q <= 1'b1;
						if (res_d.learned) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request fields, compare pipeline and result.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			mode_q <= mode;
			key_q <= {vlan, mac};
			port_q <= port;
		end
		cmp_idx_s1 <= rd_idx_q[AW-1:0];
		if (key_match) begin
			hit_idx_q <= cmp_idx_s1;
			hit_port_q <= rd_word[PORT_W-1:0];
		end
		if (finish_load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = res_q.hit;
	assign learned = res_q.learned;
	assign moved = res_q.moved;
	assign refreshed = res_q.refreshed;
	assign full_res = res_q.full_res;
	assign found_port = res_q.found_port;

	// At most one learn outcome is reported per request.
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({res_q.learned, res_q.moved, res_q.refreshed, res_q.full_res}))
		else $error("more than one learn outcome in a result");

	// A move or a refresh always comes from an existing entry.
	a_update_hits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.moved || res_q.refreshed) |-> res_q.hit)
		else $error("move or refresh reported without a hit");

	// The fill count only grows together with a learned result.
	a_cnt_learn: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |-> out_valid_q && res_q.learned)
		else $error("fill count changed without a learned result");

	// The fill count never passes the table size.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && cnt_q == CW'(TABLE_ENTRIES) |-> !res_d.learned)
		else $error("insert attempted into a full table");

endmodule
